// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority packet queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int ID_W   = 32;
  localparam int PRIO_W = 8;
  localparam int SIZE_W = 32;
  localparam int TIME_W = 32;
  localparam int HELD_W = 5;

  localparam logic [1:0] ACT_INSERT    = 2'd0;
  localparam logic [1:0] ACT_PULL_HEAD = 2'd1;
  localparam logic [1:0] ACT_PULL_TAIL = 2'd2;
  localparam logic [1:0] ACT_PULL_THR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CELL_KEEP       = 2'd0;
  localparam logic [1:0] CELL_LOAD       = 2'd1;
  localparam logic [1:0] CELL_FROM_LEFT  = 2'd2;
  localparam logic [1:0] CELL_FROM_RIGHT = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] stamp;
  } rec_t;

  typedef struct packed {
    logic [1:0] op;
  } cell_ctrl_t;

  typedef struct packed {
    logic ahead;
    logic at_or_below;
  } cell_flag_t;

endpackage

// ----- src/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a record, compares it with the
// incoming record and threshold, and loads from the new record or a neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::rec_t      new_rec,
  input  spq_pkg::rec_t      left_rec,
  input  spq_pkg::rec_t      right_rec,
  input  logic [7:0]         thr,
  output spq_pkg::rec_t      rec,
  output spq_pkg::cell_flag_t flag
);
  import spq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_KEEP:       rec <= rec;
      CELL_LOAD:       rec <= new_rec;
      CELL_FROM_LEFT:  rec <= left_rec;
      CELL_FROM_RIGHT: rec <= right_rec;
    endcase
  end

  // new record sorts ahead of this one
  assign flag.ahead = (new_rec.prio > rec.prio) ||
                      ((new_rec.prio == rec.prio) && (new_rec.stamp < rec.stamp));
  assign flag.at_or_below = (rec.prio <= thr);

endmodule

// ----- src/sorted_priority_packet_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_packet_queue
// Shift-register priority queue: a chain of DEPTH cells kept sorted by
// descending priority, then ascending timestamp.
// ----------------------------------------------------------------------------
// result: the output fields are registered when the input transaction is accepted
// throughput: one transaction per cycle unless the output stalls; every cell
//   compares and shifts in the same cycle, so the result register alone paces the input
// reset: clears the record count and the result valid; cell contents are
//   not cleared and are only read below the count
module sorted_priority_packet_queue #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [31:0] item_id,
  input  logic [7:0]  item_priority,
  input  logic [31:0] item_size,
  input  logic [31:0] item_time,
  input  logic [7:0]  threshold_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] out_id,
  output logic [7:0]  out_priority,
  output logic [31:0] out_size,
  output logic [31:0] out_time,
  output logic [4:0]  held_count
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_acc;
  logic             is_insert;
  logic             full;
  logic             empty;
  logic             do_update;
  logic [1:0]       status_next;
  rec_t             new_rec;
  rec_t             pulled;
  rec_t             cell_rec  [DEPTH];
  cell_flag_t       cell_flag [DEPTH];
  cell_ctrl_t       cell_ctrl [DEPTH];
  logic [DEPTH-1:0] ins_mark;
  logic [DEPTH-1:0] pull_mark;
  logic [DEPTH-1:0] pull_sel;
  logic [CNT_W+HELD_W-1:0] cnt_ext;

  assign in_ready  = !out_valid || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign is_insert = (action == ACT_INSERT);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign do_update = in_acc && (is_insert ? !full : !empty);

  assign new_rec.id    = item_id;
  assign new_rec.prio  = item_priority;
  assign new_rec.size  = item_size;
  assign new_rec.stamp = item_time;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic occ;
    logic at_tail;

    assign occ     = (CNT_W'(k) < count);
    assign at_tail = (CNT_W'(k + 1) >= count);

    // insert point: first slot the new record beats, or the first free one
    assign ins_mark[k] = !occ || cell_flag[k].ahead;

    always_comb begin
      unique case (action)
        ACT_INSERT:    pull_mark[k] = 1'b0;
        ACT_PULL_HEAD: pull_mark[k] = 1'b1;
        ACT_PULL_TAIL: pull_mark[k] = at_tail;
        ACT_PULL_THR:  pull_mark[k] = cell_flag[k].at_or_below || at_tail;
      endcase
    end

    if (k == 0) begin : g_first
      assign pull_sel[k] = pull_mark[k];
    end else begin : g_rest
      assign pull_sel[k] = pull_mark[k] && !pull_mark[k-1];
    end

    always_comb begin
      cell_ctrl[k].op = CELL_KEEP;
      if (do_update) begin
        if (is_insert) begin
          if ((k > 0) && ins_mark[(k > 0) ? k - 1 : 0]) begin
            cell_ctrl[k].op = CELL_FROM_LEFT;
          end else if (ins_mark[k]) begin
            cell_ctrl[k].op = CELL_LOAD;
          end
        end else if (pull_mark[k]) begin
          cell_ctrl[k].op = CELL_FROM_RIGHT;
        end
      end
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[k]),
      .new_rec   (new_rec),
      .left_rec  (cell_rec[(k > 0) ? k - 1 : 0]),
      .right_rec (cell_rec[(k < DEPTH - 1) ? k + 1 : k]),
      .thr       (threshold_priority),
      .rec       (cell_rec[k]),
      .flag      (cell_flag[k])
    );
  end

  // one-hot pick of the pulled record
  always_comb begin
    pulled = '0;
    for (int k = 0; k < DEPTH; k++) begin
      pulled = pulled | (pull_sel[k] ? cell_rec[k] : '0);
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (is_insert) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else begin
      count_next = count - 1'b1;
    end
  end

  assign cnt_ext = {{HELD_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status     <= status_next;
      held_count <= cnt_ext[HELD_W-1:0];
      if (!is_insert && !empty) begin
        out_id       <= pulled.id;
        out_priority <= pulled.prio;
        out_size     <= pulled.size;
        out_time     <= pulled.stamp;
      end else begin
        out_id       <= '0;
        out_priority <= '0;
        out_size     <= '0;
        out_time     <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("record count above depth");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_insert && full) |=> (status == ST_FULL) && $stable(count))
    else $error("insert into full queue changed state");

  a_pull_dec: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !is_insert && !empty) |=> (count == CNT_W'($past(count) - 1'b1)))
    else $error("pull did not remove one record");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (cell_rec[0].prio >= cell_rec[1].prio))
    else $error("head cells out of order");

endmodule

// ----- tb/tb_sorted_priority_packet_queue.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_packet_queue
// Drives insert and pull transactions into the sorted priority packet queue,
// tracks the queue contents in a shadow model and checks every result field.
// A directed opening covers empty pulls, a full queue, ties and threshold
// pulls; random phases follow with varied action mixes, narrow and wide keys,
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sorted_priority_packet_queue;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 230;

  typedef struct {
    logic [1:0]        status;
    rec_t              rec;
    logic [HELD_W-1:0] held;
  } queue_outcome_t;

  class queue_tracker;
    rec_t           slots [QUEUE_DEPTH];
    int unsigned    held;
    queue_outcome_t pending [$];
    int unsigned    errors;
    int unsigned    inserts_taken;
    int unsigned    inserts_refused;
    int unsigned    pulls_done;
    int unsigned    pulls_empty;
    int unsigned    thr_misses;
    int unsigned    peak_held;

    function new();
      held = 0;
      errors = 0;
      inserts_taken = 0;
      inserts_refused = 0;
      pulls_done = 0;
      pulls_empty = 0;
      thr_misses = 0;
      peak_held = 0;
    endfunction

    function void note_action(logic [1:0] act, rec_t rec, logic [PRIO_W-1:0] thr);
      queue_outcome_t res;
      int             pos;
      int             k;
      res.status = ST_OK;
      res.rec = '0;
      if (act == ACT_INSERT) begin
        if (held >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
          inserts_refused++;
        end else begin
          pos = held;
          for (k = 0; k < held; k++) begin
            if (rec.prio > slots[k].prio ||
                (rec.prio == slots[k].prio && rec.stamp < slots[k].stamp)) begin
              pos = k;
              break;
            end
          end
          for (k = held; k > pos; k--) slots[k] = slots[k-1];
          slots[pos] = rec;
          held++;
          inserts_taken++;
          if (held > peak_held) peak_held = held;
        end
      end else if (held == 0) begin
        res.status = ST_EMPTY;
        pulls_empty++;
      end else begin
        pos = (act == ACT_PULL_HEAD) ? 0 : held - 1;
        if (act == ACT_PULL_THR) begin
          pos = -1;
          for (k = 0; k < held; k++) begin
            if (slots[k].prio <= thr) begin
              pos = k;
              break;
            end
          end
          if (pos < 0) begin
            pos = held - 1;
            thr_misses++;
          end
        end
        res.rec = slots[pos];
        for (k = pos; k + 1 < held; k++) slots[k] = slots[k+1];
        held--;
        pulls_done++;
      end
      res.held = held[HELD_W-1:0];
      pending.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio, logic [SIZE_W-1:0] size,
                               logic [TIME_W-1:0] stamp, logic [HELD_W-1:0] cnt);
      queue_outcome_t exp;
      if (pending.size() == 0) begin
        $error("result transaction with no pending prediction");
        errors++;
        return;
      end
      exp = pending.pop_front();
      compare_field("status", 32'(exp.status), 32'(st));
      compare_field("out_id", exp.rec.id, id);
      compare_field("out_priority", 32'(exp.rec.prio), 32'(prio));
      compare_field("out_size", exp.rec.size, size);
      compare_field("out_time", exp.rec.stamp, stamp);
      compare_field("held_count", 32'(exp.held), 32'(cnt));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  action;
  logic [31:0] item_id;
  logic [7:0]  item_priority;
  logic [31:0] item_size;
  logic [31:0] item_time;
  logic [7:0]  threshold_priority;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [31:0] out_id;
  logic [7:0]  out_priority;
  logic [31:0] out_size;
  logic [31:0] out_time;
  logic [4:0]  held_count;

  logic        stall_on;
  logic        hold_off;
  logic        hold_go;
  int unsigned cycle_count = 0;
  queue_tracker tracker;

  sorted_priority_packet_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .item_id(item_id),
    .item_priority(item_priority),
    .item_size(item_size),
    .item_time(item_time),
    .threshold_priority(threshold_priority),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_id(out_id),
    .out_priority(out_priority),
    .out_size(out_size),
    .out_time(out_time),
    .held_count(held_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sorted_priority_packet_queue failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        tracker.check_result(status, out_id, out_priority, out_size, out_time, held_count);
      if (hold_off) out_ready <= 1'b0;
      else if (stall_on) out_ready <= ($urandom_range(0, 99) >= 36);
      else out_ready <= 1'b1;
    end
  end

  // long output hold-off so the queue backs up and stalls its input
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic offer_action(input logic [1:0] act, input logic [31:0] id,
                              input logic [7:0] prio, input logic [31:0] size,
                              input logic [31:0] stamp, input logic [7:0] thr);
    rec_t rec;
    while (stall_on && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    item_id <= id;
    item_priority <= prio;
    item_size <= size;
    item_time <= stamp;
    threshold_priority <= thr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rec.id = id;
    rec.prio = prio;
    rec.size = size;
    rec.stamp = stamp;
    tracker.note_action(act, rec, thr);
  endtask

  task automatic run_directed();
    logic [7:0]  prio_tab [16];
    logic [31:0] stamp_tab [16];
    logic [31:0] id;
    logic [31:0] size;
    int          i;
    prio_tab = '{8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 8'd128, 8'd1, 8'd0,
                 8'd200, 8'd200, 8'd64, 8'd7, 8'd128, 8'd255, 8'd3, 8'd90};
    stamp_tab = '{32'h0, 32'hFFFF_FFFF, 32'd5, 32'd5, 32'd2, 32'hFFFF_FFFF, 32'h0,
                  32'h0, 32'd9, 32'd9, 32'hFFFF_FFFF, 32'd1, 32'd5, 32'd0,
                  32'h8000_0000, 32'd77};
    offer_action(ACT_PULL_HEAD, $urandom(), 8'hFF, $urandom(), $urandom(), 8'hFF);
    offer_action(ACT_PULL_TAIL, $urandom(), 8'h00, $urandom(), $urandom(), 8'h00);
    offer_action(ACT_PULL_THR, $urandom(), 8'hA5, $urandom(), $urandom(), 8'h5A);
    for (i = 0; i < 16; i++) begin
      id = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
      size = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
      offer_action(ACT_INSERT, id, prio_tab[i], size, stamp_tab[i],
                   8'($urandom_range(0, 255)));
    end
    offer_action(ACT_INSERT, 32'hDEAD_0001, 8'd255, 32'h1, 32'h0, 8'd0);
    offer_action(ACT_PULL_TAIL, $urandom(), 8'd0, $urandom(), $urandom(), 8'd0);
    offer_action(ACT_PULL_THR, $urandom(), 8'd0, $urandom(), $urandom(), 8'd0);
    offer_action(ACT_PULL_THR, $urandom(), 8'd0, $urandom(), $urandom(), 8'd255);
    offer_action(ACT_PULL_THR, $urandom(), 8'd0, $urandom(), $urandom(), 8'd128);
    offer_action(ACT_PULL_HEAD, $urandom(), 8'd0, $urandom(), $urandom(), 8'd0);
  endtask

  task automatic run_random_phase(input int count, input int insert_pct, input bit narrow);
    logic [1:0]  act;
    logic [7:0]  prio;
    logic [31:0] stamp;
    logic [7:0]  thr;
    int          i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < insert_pct) begin
        act = ACT_INSERT;
      end else begin
        case ($urandom_range(1, 3))
          1: act = ACT_PULL_HEAD;
          2: act = ACT_PULL_TAIL;
          default: act = ACT_PULL_THR;
        endcase
      end
      if (narrow) begin
        prio = 8'($urandom_range(0, 3));
        stamp = $urandom_range(0, 3);
        thr = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) prio = ~prio;
        if ($urandom_range(0, 1)) stamp = ~stamp;
        if ($urandom_range(0, 1)) thr = ~thr;
      end else begin
        prio = 8'($urandom_range(0, 255));
        stamp = $urandom();
        thr = 8'($urandom_range(0, 255));
      end
      offer_action(act, $urandom(), prio, $urandom(), stamp, thr);
    end
  endtask

  initial begin
    int insert_mix [8];
    int p;
    insert_mix = '{80, 20, 55, 95, 5, 50, 65, 35};
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_INSERT;
    item_id = '0;
    item_priority = '0;
    item_size = '0;
    item_time = '0;
    threshold_priority = '0;
    stall_on = 1'b0;
    hold_go = 1'b0;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    stall_on <= 1'b1;
    run_directed();
    for (p = 0; p < 8; p++) begin
      stall_on <= (p != 2);
      if (p == 3) hold_go = 1'b1;
      run_random_phase(PHASE_ITEMS, insert_mix[p], p[0]);
    end
    in_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("covered %0d inserts (%0d refused on full), %0d pulls (%0d on empty)",
             tracker.inserts_taken, tracker.inserts_refused,
             tracker.pulls_done, tracker.pulls_empty);
    $display("threshold pulls falling back to tail: %0d, peak occupancy %0d of %0d",
             tracker.thr_misses, tracker.peak_held, QUEUE_DEPTH);
    if (tracker.errors == 0) begin
      $display("tb_sorted_priority_packet_queue passed");
    end else begin
      $display("tb_sorted_priority_packet_queue failed");
    end
    $finish;
  end

endmodule
